@@ src/i2c_bitbang_master_assert.svh @@
// Assertion macros for the I2C bit-level master.
// Included by the RTL files that check their own logic; needs no package.
`ifndef I2C_BITBANG_MASTER_ASSERT_SVH
`define I2C_BITBANG_MASTER_ASSERT_SVH

// Check a property on every rising edge, skipped while reset is low.
`define I2C_BB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define I2C_BB_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/i2c_bb_pkg.sv @@
// Shared types and constants for the I2C bit-level master.
// No dependencies; used by the interfaces, the step logic and the top level.
`timescale 1ns / 1ps

package i2c_bb_pkg;

    localparam int BYTE_W  = 8;
    localparam int PHASE_W = 5;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4
    } t_op;

    // Step numbers within a command
    localparam logic [PHASE_W-1:0] PH_IDLE     = 5'd0;
    localparam logic [PHASE_W-1:0] PH_FIRST    = 5'd1;
    localparam logic [PHASE_W-1:0] PH_SECOND   = 5'd2;
    localparam logic [PHASE_W-1:0] PH_THIRD    = 5'd3;
    localparam logic [PHASE_W-1:0] PH_BITS_END = 5'd24;
    localparam logic [PHASE_W-1:0] PH_ACK_A    = 5'd25;
    localparam logic [PHASE_W-1:0] PH_ACK_B    = 5'd26;
    localparam logic [PHASE_W-1:0] PH_ACK_C    = 5'd27;
    localparam logic [PHASE_W-1:0] PH_WR_LAST  = 5'd28;

    // Position within one bit slot
    localparam logic [1:0] SUB_LOW  = 2'd0;
    localparam logic [1:0] SUB_DATA = 2'd1;
    localparam logic [1:0] SUB_HIGH = 2'd2;

    typedef struct packed {
        logic scl_lvl;
        logic scl_drv;
        logic sda_lvl;
        logic sda_drv;
    } t_pins;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        t_op                op;
        logic [1:0]         sub;
        logic [BYTE_W-1:0]  shreg;
        logic               ack;
        t_pins              pins;
    } t_state;

    typedef struct packed {
        logic [2:0]        req_type;
        logic [BYTE_W-1:0] tx_byte;
        logic              send_nack;
        logic              sda_in;
    } t_req;

    typedef struct packed {
        logic              scl_level;
        logic              scl_drive;
        logic              sda_level;
        logic              sda_drive;
        logic              busy_res;
        logic              done_res;
        logic              nack_seen;
        logic [BYTE_W-1:0] rx_byte;
        logic              rejected;
    } t_res;

endpackage

@@ src/i2c_bb_req_if.sv @@
// Request channel: one bus tick item with an optional command.
// Depends on i2c_bb_pkg.
`timescale 1ns / 1ps

interface i2c_bb_req_if;
    logic              valid;
    logic              ready;
    i2c_bb_pkg::t_req  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/i2c_bb_res_if.sv @@
// Result channel: pin levels and status for one bus tick.
// Depends on i2c_bb_pkg.
`timescale 1ns / 1ps

interface i2c_bb_res_if;
    logic              valid;
    logic              ready;
    i2c_bb_pkg::t_res  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/i2c_bb_step.sv @@
// One bus tick of the command sequencer: next state and result from state and item.
// Depends on i2c_bb_pkg.
`timescale 1ns / 1ps

module i2c_bb_step (
    input  i2c_bb_pkg::t_state i_state,
    input  i2c_bb_pkg::t_req   i_req,
    output i2c_bb_pkg::t_state o_state,
    output i2c_bb_pkg::t_res   o_res
);

    logic                           busy_now;
    logic                           start_cmd;
    logic                           active;
    logic                           last;
    logic                           nack_bit;
    logic [i2c_bb_pkg::PHASE_W-1:0] step;
    i2c_bb_pkg::t_state             base;

    // Decode: pick up a new command while idle
    always_comb begin
        busy_now  = (i_state.phase != i2c_bb_pkg::PH_IDLE);
        start_cmd = !busy_now &&
                    (i_req.req_type == i2c_bb_pkg::OP_START ||
                     i_req.req_type == i2c_bb_pkg::OP_STOP  ||
                     i_req.req_type == i2c_bb_pkg::OP_WRITE ||
                     i_req.req_type == i2c_bb_pkg::OP_READ);
        active    = busy_now || start_cmd;
        step      = i_state.phase + i2c_bb_pkg::PHASE_W'(1);
        base      = i_state;
        if (start_cmd) begin
            base.op  = i2c_bb_pkg::t_op'(i_req.req_type);
            base.sub = i2c_bb_pkg::SUB_LOW;
            if (i_req.req_type == i2c_bb_pkg::OP_WRITE) begin
                base.shreg = i_req.tx_byte;
            end else if (i_req.req_type == i2c_bb_pkg::OP_READ) begin
                base.shreg = '0;
                base.ack   = i_req.send_nack;
            end
        end
    end

    // Next state: run one step of the current sequence
    always_comb begin
        o_state  = base;
        last     = 1'b0;
        nack_bit = 1'b0;
        if (active) begin
            case (base.op)
                i2c_bb_pkg::OP_START: begin
                    if (step == i2c_bb_pkg::PH_FIRST) begin
                        o_state.pins.scl_drv = 1'b1;
                        o_state.pins.sda_drv = 1'b1;
                        o_state.pins.sda_lvl = 1'b1;
                    end else if (step == i2c_bb_pkg::PH_SECOND) begin
                        o_state.pins.scl_lvl = 1'b1;
                    end else if (step == i2c_bb_pkg::PH_THIRD) begin
                        o_state.pins.sda_lvl = 1'b0;
                    end else begin
                        o_state.pins.scl_lvl = 1'b0;
                        last = 1'b1;
                    end
                end
                i2c_bb_pkg::OP_STOP: begin
                    if (step == i2c_bb_pkg::PH_FIRST) begin
                        o_state.pins.sda_drv = 1'b1;
                        o_state.pins.scl_lvl = 1'b0;
                    end else if (step == i2c_bb_pkg::PH_SECOND) begin
                        o_state.pins.sda_lvl = 1'b0;
                    end else if (step == i2c_bb_pkg::PH_THIRD) begin
                        o_state.pins.scl_lvl = 1'b1;
                    end else begin
                        o_state.pins.sda_lvl = 1'b1;
                        o_state.pins.scl_drv = 1'b0;
                        o_state.pins.sda_drv = 1'b0;
                        last = 1'b1;
                    end
                end
                i2c_bb_pkg::OP_WRITE: begin
                    if (step <= i2c_bb_pkg::PH_BITS_END) begin
                        case (base.sub)
                            i2c_bb_pkg::SUB_LOW: begin
                                if (step == i2c_bb_pkg::PH_FIRST) begin
                                    o_state.pins.sda_drv = 1'b1;
                                end
                                o_state.pins.scl_lvl = 1'b0;
                                o_state.sub = i2c_bb_pkg::SUB_DATA;
                            end
                            i2c_bb_pkg::SUB_DATA: begin
                                // Send MSB first, shift the next bit up
                                o_state.pins.sda_lvl = base.shreg[i2c_bb_pkg::BYTE_W-1];
                                o_state.shreg = {base.shreg[i2c_bb_pkg::BYTE_W-2:0], 1'b0};
                                o_state.sub = i2c_bb_pkg::SUB_HIGH;
                            end
                            default: begin
                                o_state.pins.scl_lvl = 1'b1;
                                o_state.sub = i2c_bb_pkg::SUB_LOW;
                            end
                        endcase
                    end else if (step == i2c_bb_pkg::PH_ACK_A) begin
                        o_state.pins.scl_lvl = 1'b0;
                    end else if (step == i2c_bb_pkg::PH_ACK_B) begin
                        o_state.pins.sda_drv = 1'b0;
                        o_state.pins.sda_lvl = 1'b1;
                    end else if (step == i2c_bb_pkg::PH_ACK_C) begin
                        o_state.pins.scl_lvl = 1'b1;
                    end else begin
                        nack_bit = i_req.sda_in;
                        o_state.pins.scl_lvl = 1'b0;
                        last = 1'b1;
                    end
                end
                i2c_bb_pkg::OP_READ: begin
                    if (step <= i2c_bb_pkg::PH_BITS_END) begin
                        case (base.sub)
                            i2c_bb_pkg::SUB_LOW: begin
                                if (step == i2c_bb_pkg::PH_FIRST) begin
                                    o_state.pins.sda_drv = 1'b0;
                                end
                                o_state.pins.scl_lvl = 1'b1;
                                o_state.sub = i2c_bb_pkg::SUB_DATA;
                            end
                            i2c_bb_pkg::SUB_DATA: begin
                                o_state.shreg = {base.shreg[i2c_bb_pkg::BYTE_W-2:0],
                                                 i_req.sda_in};
                                o_state.sub = i2c_bb_pkg::SUB_HIGH;
                            end
                            default: begin
                                o_state.pins.scl_lvl = 1'b0;
                                o_state.sub = i2c_bb_pkg::SUB_LOW;
                            end
                        endcase
                    end else if (step == i2c_bb_pkg::PH_ACK_A) begin
                        o_state.pins.sda_drv = 1'b1;
                        o_state.pins.sda_lvl = base.ack;
                    end else if (step == i2c_bb_pkg::PH_ACK_B) begin
                        o_state.pins.scl_lvl = 1'b1;
                    end else begin
                        o_state.pins.scl_lvl = 1'b0;
                        o_state.pins.sda_drv = 1'b0;
                        last = 1'b1;
                    end
                end
                default: begin
                    last = 1'b1;
                end
            endcase
            if (last) begin
                o_state.phase = i2c_bb_pkg::PH_IDLE;
                o_state.op    = i2c_bb_pkg::OP_NONE;
            end else begin
                o_state.phase = step;
            end
        end
    end

    // Result fields
    always_comb begin
        o_res           = '0;
        o_res.scl_level = o_state.pins.scl_lvl;
        o_res.scl_drive = o_state.pins.scl_drv;
        o_res.sda_level = o_state.pins.sda_lvl;
        o_res.sda_drive = o_state.pins.sda_drv;
        o_res.busy_res  = active;
        o_res.done_res  = active && last;
        o_res.rejected  = busy_now && (i_req.req_type != 3'(i2c_bb_pkg::OP_NONE));
        if (active && last) begin
            if (base.op == i2c_bb_pkg::OP_WRITE) begin
                o_res.nack_seen = nack_bit;
            end else if (base.op == i2c_bb_pkg::OP_READ) begin
                o_res.rx_byte = o_state.shreg;
            end
        end
    end

endmodule

@@ src/i2c_bitbang_master.sv @@
// Top level of the I2C bit-level master: sequencer state and result register.
// Depends on i2c_bb_pkg, i2c_bb_req_if, i2c_bb_res_if, i2c_bb_step and the assert header.
`timescale 1ns / 1ps
//
//  channel  | dir | modport | payload
//  ---------+-----+---------+-----------------------------------------------
//  i_req    | in  | sink    | req_type, tx_byte, send_nack, sda_in
//  o_res    | out | source  | scl/sda level and drive, busy_res, done_res,
//           |     |         | nack_seen, rx_byte, rejected
//
//  Each request item is one bus tick and yields one result item in the cycle
//  after it is accepted; one item per cycle is sustained while o_res takes results.
//  The single step of the sequencer sits between the state register and the
//  result register; the result register takes a new item in the same cycle
//  as the waiting result leaves, so a stall on o_res stops i_req only while
//  the register is full and the result is not taken.
//  A synchronous reset returns to idle with both lines released high.
//  A start or stop takes 4 items, a write 28, a read 27.

module i2c_bitbang_master (
    input  logic               i_clk,
    input  logic               i_rst_n,
    i2c_bb_req_if.sink         i_req,
    i2c_bb_res_if.source       o_res
);

`include "i2c_bitbang_master_assert.svh"

    i2c_bb_pkg::t_state r_state;
    i2c_bb_pkg::t_state n_state;
    i2c_bb_pkg::t_res   r_res;
    i2c_bb_pkg::t_res   n_res;
    logic               r_out_valid;
    logic               accept;

    // Take a new item whenever the result register is free or being drained
    assign i_req.ready = !r_out_valid || o_res.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_res;

    i2c_bb_step u_step (
        .i_state (r_state),
        .i_req   (i_req.data),
        .o_state (n_state),
        .o_res   (n_res)
    );

    // Advance the sequencer by one tick per accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase        <= i2c_bb_pkg::PH_IDLE;
            r_state.op           <= i2c_bb_pkg::OP_NONE;
            r_state.sub          <= i2c_bb_pkg::SUB_LOW;
            r_state.shreg        <= '0;
            r_state.ack          <= 1'b0;
            r_state.pins.scl_lvl <= 1'b1;
            r_state.pins.scl_drv <= 1'b0;
            r_state.pins.sda_lvl <= 1'b1;
            r_state.pins.sda_drv <= 1'b0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    `I2C_BB_ASSERT(a_phase_range, i_clk, i_rst_n,
        r_state.phase <= i2c_bb_pkg::PH_WR_LAST, "phase out of range")
    `I2C_BB_ASSERT(a_idle_op, i_clk, i_rst_n,
        (r_state.phase == i2c_bb_pkg::PH_IDLE) == (r_state.op == i2c_bb_pkg::OP_NONE),
        "op and phase disagree on idle")
    `I2C_BB_ASSERT(a_done_busy, i_clk, i_rst_n,
        r_out_valid && r_res.done_res |-> r_res.busy_res, "done without busy")
    `I2C_BB_ASSERT(a_done_idle, i_clk, i_rst_n,
        accept && n_res.done_res |=> r_state.phase == i2c_bb_pkg::PH_IDLE,
        "sequencer not idle after done")
    `I2C_BB_ASSERT(a_reject_busy, i_clk, i_rst_n,
        accept && n_res.rejected |-> r_state.phase != i2c_bb_pkg::PH_IDLE,
        "command rejected while idle")

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the I2C bit-level master: bus ticks in, pin and status items out.
// Depends on i2c_bb_pkg, i2c_bb_req_if, i2c_bb_res_if and the RTL under src.

module tb;
    import i2c_bb_pkg::*;

    localparam int TICK_TARGET  = 1600;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RESET_CYCLES = 11;
    localparam int IDLE_PCT     = 19;
    localparam int CALM_FIRST   = 700;
    localparam int CALM_LAST    = 1000;
    localparam int MSB_BIT      = BYTE_W - 1;
    localparam int COND_LEN     = 4;
    localparam int N_DIRECTED   = 14;

    // Request codes above the defined operations
    localparam logic [2:0] REQ_ODD_LO = 3'd5;
    localparam logic [2:0] REQ_ODD_HI = 3'd7;

    localparam t_res IDLE_RES = '{scl_level: 1'b1, scl_drive: 1'b0, sda_level: 1'b1,
                                  sda_drive: 1'b0, busy_res: 1'b0, done_res: 1'b0,
                                  nack_seen: 1'b0, rx_byte: 8'h00, rejected: 1'b0};
    localparam t_res STOP_DONE_RES = '{scl_level: 1'b1, scl_drive: 1'b0, sda_level: 1'b1,
                                       sda_drive: 1'b0, busy_res: 1'b1, done_res: 1'b1,
                                       nack_seen: 1'b0, rx_byte: 8'h00, rejected: 1'b0};

    typedef struct {
        logic [2:0]  code;
        logic [7:0]  tx;
        logic        nack;
        logic [31:0] sda_bits;   // sda_in for each tick of the command, tick 0 in bit 0
        logic [2:0]  intruder;   // request sent on the second tick, while busy
        logic        typed;      // want holds the result of the command's last tick
        t_res        want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    i2c_bb_req_if req_ch ();
    i2c_bb_res_if res_ch ();

    i2c_bitbang_master u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    // Bus master state as the bench sees it
    logic [PHASE_W-1:0] bus_phase;
    t_op                bus_op;
    logic [BYTE_W-1:0]  bus_shift;
    logic               rd_ack_lvl;
    logic               wr_nack;
    logic               scl_lvl, scl_drv, sda_lvl, sda_drv;

    t_res pin_results [$];
    t_res want_res;

    int ticks_sent      = 0;
    int results_checked = 0;
    int errors          = 0;
    int rejects_seen    = 0;
    int nacks_seen      = 0;
    int quiet_cycles    = 0;
    int cmd_tally [5]   = '{default: 0};

    t_dir_row dir_rows [N_DIRECTED] = '{
        '{OP_NONE,    8'h00, 1'b0, 32'h0000_0000, OP_NONE,  1'b1, IDLE_RES},
        '{REQ_ODD_LO, 8'h00, 1'b0, 32'h0000_0000, OP_NONE,  1'b1, IDLE_RES},
        '{REQ_ODD_HI, 8'hFF, 1'b1, 32'hFFFF_FFFF, OP_NONE,  1'b1, IDLE_RES},
        '{OP_STOP,    8'h00, 1'b0, 32'h0000_0000, OP_NONE,  1'b1, STOP_DONE_RES},
        '{OP_START,   8'h00, 1'b0, 32'h0000_0000, OP_WRITE, 1'b0, '0},
        '{OP_WRITE,   8'h00, 1'b0, 32'h0000_0000, OP_NONE,  1'b0, '0},
        '{OP_WRITE,   8'hFF, 1'b1, 32'hFFFF_FFFF, OP_READ,  1'b0, '0},
        '{OP_WRITE,   8'hA5, 1'b0, 32'h5A5A_5A5A, OP_NONE,  1'b0, '0},
        '{OP_READ,    8'h00, 1'b0, 32'hFFFF_FFFF, OP_NONE,  1'b0, '0},
        '{OP_READ,    8'hFF, 1'b1, 32'h0000_0000, REQ_ODD_HI, 1'b0, '0},
        '{OP_READ,    8'h3C, 1'b0, 32'h3C3C_3C3C, OP_START, 1'b0, '0},
        '{OP_START,   8'h00, 1'b0, 32'h0000_0000, OP_NONE,  1'b0, '0},
        '{OP_STOP,    8'h00, 1'b0, 32'h0000_0000, OP_STOP,  1'b0, '0},
        '{OP_NONE,    8'h00, 1'b0, 32'h0000_0000, OP_NONE,  1'b1, IDLE_RES}
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Drop a side now and then, except inside the calm window.
    function automatic logic take_break();
        if (ticks_sent >= CALM_FIRST && ticks_sent < CALM_LAST)
            return 1'b0;
        return $urandom_range(99) < IDLE_PCT;
    endfunction

    function automatic int cmd_ticks(logic [2:0] code);
        case (code)
            OP_START, OP_STOP: return COND_LEN;
            OP_WRITE:          return PH_WR_LAST;
            OP_READ:           return PH_ACK_C;
            default:           return 1;
        endcase
    endfunction

    task automatic reset_bus_model();
        bus_phase  = PH_IDLE;
        bus_op     = OP_NONE;
        bus_shift  = '0;
        rd_ack_lvl = 1'b0;
        wr_nack    = 1'b0;
        scl_lvl    = 1'b1;
        scl_drv    = 1'b0;
        sda_lvl    = 1'b1;
        sda_drv    = 1'b0;
    endtask

    // Advance the bus master by one tick and return the pins and status it shows.
    function automatic t_res bus_tick(t_req rq);
        t_res               r;
        logic [PHASE_W-1:0] s;
        logic [1:0]         sub;
        int                 k;
        logic               active;
        logic               last;

        r      = '0;
        active = 1'b0;
        last   = 1'b0;

        if (bus_phase != PH_IDLE) begin
            // a request in the middle of a command is flagged and dropped
            r.rejected = (rq.req_type != OP_NONE);
            active     = 1'b1;
        end else if (rq.req_type >= OP_START && rq.req_type <= OP_READ) begin
            bus_op = t_op'(rq.req_type);
            if (bus_op == OP_WRITE) begin
                bus_shift = rq.tx_byte;
            end else if (bus_op == OP_READ) begin
                bus_shift  = '0;
                rd_ack_lvl = rq.send_nack;
            end
            active = 1'b1;
        end

        if (active) begin
            s   = bus_phase + 1'b1;
            k   = (int'(s) - 1) / 3;
            sub = 2'((int'(s) - 1) % 3);
            r.busy_res = 1'b1;
            case (bus_op)
                OP_START: begin
                    case (s)
                        PH_FIRST: begin
                            scl_drv = 1'b1;
                            sda_drv = 1'b1;
                            sda_lvl = 1'b1;
                        end
                        PH_SECOND: scl_lvl = 1'b1;
                        PH_THIRD:  sda_lvl = 1'b0;
                        default: begin
                            scl_lvl = 1'b0;
                            last    = 1'b1;
                        end
                    endcase
                end
                OP_STOP: begin
                    case (s)
                        PH_FIRST: begin
                            sda_drv = 1'b1;
                            scl_lvl = 1'b0;
                        end
                        PH_SECOND: sda_lvl = 1'b0;
                        PH_THIRD:  scl_lvl = 1'b1;
                        default: begin
                            sda_lvl = 1'b1;
                            scl_drv = 1'b0;
                            sda_drv = 1'b0;
                            last    = 1'b1;
                        end
                    endcase
                end
                OP_WRITE: begin
                    if (s <= PH_BITS_END) begin
                        if (sub == SUB_LOW) begin
                            if (s == PH_FIRST)
                                sda_drv = 1'b1;
                            scl_lvl = 1'b0;
                        end else if (sub == SUB_DATA) begin
                            sda_lvl = bus_shift[MSB_BIT - k];
                        end else begin
                            scl_lvl = 1'b1;
                        end
                    end else begin
                        case (s)
                            PH_ACK_A: scl_lvl = 1'b0;
                            PH_ACK_B: begin
                                sda_drv = 1'b0;
                                sda_lvl = 1'b1;
                            end
                            PH_ACK_C: scl_lvl = 1'b1;
                            default: begin
                                wr_nack = rq.sda_in;
                                scl_lvl = 1'b0;
                                last    = 1'b1;
                            end
                        endcase
                    end
                end
                OP_READ: begin
                    if (s <= PH_BITS_END) begin
                        if (sub == SUB_LOW) begin
                            if (s == PH_FIRST)
                                sda_drv = 1'b0;
                            scl_lvl = 1'b1;
                        end else if (sub == SUB_DATA) begin
                            bus_shift = {bus_shift[MSB_BIT-1:0], rq.sda_in};
                        end else begin
                            scl_lvl = 1'b0;
                        end
                    end else begin
                        case (s)
                            PH_ACK_A: begin
                                sda_drv = 1'b1;
                                sda_lvl = rd_ack_lvl;
                            end
                            PH_ACK_B: scl_lvl = 1'b1;
                            default: begin
                                scl_lvl = 1'b0;
                                sda_drv = 1'b0;
                                last    = 1'b1;
                            end
                        endcase
                    end
                end
                default: last = 1'b1;
            endcase

            if (last) begin
                r.done_res = 1'b1;
                if (bus_op == OP_WRITE)
                    r.nack_seen = wr_nack;
                else if (bus_op == OP_READ)
                    r.rx_byte = bus_shift;
                bus_phase = PH_IDLE;
                bus_op    = OP_NONE;
            end else begin
                bus_phase = s;
            end
        end

        r.scl_level = scl_lvl;
        r.scl_drive = scl_drv;
        r.sda_level = sda_lvl;
        r.sda_drive = sda_drv;
        return r;
    endfunction

    // Offer one tick item; predict it once valid and ready are seen together.
    task automatic send_tick(t_req rq, logic typed, t_res want);
        t_res got;
        while (take_break()) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= rq;
        do @(negedge i_clk); while (req_ch.ready !== 1'b1);
        got = bus_tick(rq);
        pin_results.push_back(typed ? want : got);
        if (got.rejected)
            rejects_seen++;
        if (got.done_res && got.nack_seen)
            nacks_seen++;
        ticks_sent++;
        @(posedge i_clk);
    endtask

    // Send a command and the ticks that carry it to its end.
    task automatic run_cmd(logic [2:0] code, logic [7:0] tx, logic nack, logic [31:0] sda_bits,
                           logic [2:0] intruder, int intrude_at, logic typed, t_res want);
        t_req rq;
        int   n;
        n = cmd_ticks(code);
        if (code >= OP_START && code <= OP_READ)
            cmd_tally[code]++;
        for (int i = 0; i < n; i++) begin
            rq.sda_in = sda_bits[i];
            if (i == 0) begin
                rq.req_type  = code;
                rq.tx_byte   = tx;
                rq.send_nack = nack;
            end else begin
                rq.req_type  = (i == intrude_at) ? intruder : 3'(OP_NONE);
                rq.tx_byte   = 8'($urandom);
                rq.send_nack = 1'($urandom);
            end
            send_tick(rq, typed && (i == n - 1), want);
        end
    endtask

    // Random content, random line answers, and now and then a request while busy.
    task automatic run_rand(logic [2:0] code);
        logic [2:0] intruder;
        intruder = ($urandom_range(3) == 0) ? 3'($urandom_range(1, 7)) : 3'(OP_NONE);
        run_cmd(code, 8'($urandom), 1'($urandom), $urandom, intruder,
                $urandom_range(1, PH_WR_LAST - 1), 1'b0, '0);
    endtask

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    // Sink side: hold ready low with a chance of about one in five, except inside the calm window.
    always @(posedge i_clk) begin
        res_ch.ready <= i_rst_n && !take_break();
    end

    always @(negedge i_clk) begin
        if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            if (pin_results.size() == 0) begin
                $error("result item arrived with nothing expected");
                errors++;
            end else begin
                want_res = pin_results.pop_front();
                check_field("scl_level", want_res.scl_level, res_ch.data.scl_level);
                check_field("scl_drive", want_res.scl_drive, res_ch.data.scl_drive);
                check_field("sda_level", want_res.sda_level, res_ch.data.sda_level);
                check_field("sda_drive", want_res.sda_drive, res_ch.data.sda_drive);
                check_field("busy_res",  want_res.busy_res,  res_ch.data.busy_res);
                check_field("done_res",  want_res.done_res,  res_ch.data.done_res);
                check_field("nack_seen", want_res.nack_seen, res_ch.data.nack_seen);
                check_field("rx_byte",   want_res.rx_byte,   res_ch.data.rx_byte);
                check_field("rejected",  want_res.rejected,  res_ch.data.rejected);
                results_checked++;
            end
        end
    end

    // Watchdog: end the run when no item moves on either side for too long.
    always @(negedge i_clk) begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
            $display("** i2c_bitbang_master: FAILED **");
            $finish;
        end
    end

    initial begin : stimulus
        int         n_data;
        logic [2:0] code;

        i_rst_n      <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        reset_bus_model();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed commands: idle ticks, odd codes, each operation at its extremes
        for (int i = 0; i < N_DIRECTED; i++) begin
            run_cmd(dir_rows[i].code, dir_rows[i].tx, dir_rows[i].nack, dir_rows[i].sda_bits,
                    dir_rows[i].intruder, 1, dir_rows[i].typed, dir_rows[i].want);
        end

        // Random transfers: start, a few data bytes, stop; stray ticks in between
        while (ticks_sent < TICK_TARGET) begin
            if ($urandom_range(99) < 12) begin
                code = ($urandom_range(3) == 0) ? 3'(OP_NONE)
                                                : 3'($urandom_range(REQ_ODD_LO, REQ_ODD_HI));
                run_rand(code);
            end else begin
                run_rand(OP_START);
                n_data = $urandom_range(1, 4);
                repeat (n_data) begin
                    if ($urandom_range(9) == 0)
                        run_rand(OP_START);
                    if ($urandom_range(4) == 0)
                        run_rand(OP_NONE);
                    run_rand($urandom_range(1) ? OP_WRITE : OP_READ);
                end
                run_rand(OP_STOP);
            end
        end
        req_ch.valid <= 1'b0;

        while (pin_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d bus ticks: %0d start, %0d stop, %0d write and %0d read commands.",
                 ticks_sent, cmd_tally[OP_START], cmd_tally[OP_STOP],
                 cmd_tally[OP_WRITE], cmd_tally[OP_READ]);
        $display("Checked %0d result items; %0d requests refused while busy, %0d write NACKs.",
                 results_checked, rejects_seen, nacks_seen);
        if (errors == 0) begin
            $display("** i2c_bitbang_master: PASSED **");
        end else begin
            $display("** i2c_bitbang_master: FAILED **");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/i2c_bb_pkg.sv
src/i2c_bb_req_if.sv
src/i2c_bb_res_if.sv
src/i2c_bb_step.sv
src/i2c_bitbang_master.sv
tb/tb.sv
